### design/ufrg_pkg.sv
package ufrg_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] checksum;
    } reply_desc_t;

    localparam int IP_HDR_BYTES   = 20;
    localparam int UDP_HDR_BYTES  = 8;
    localparam int GREETING_BYTES = 26;

    localparam logic [7:0] VERSION_IHL = 8'h45;
    localparam logic [7:0] REPLY_TTL   = 8'd64;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [3:0] MIN_IHL     = 4'd5;

    function automatic logic [7:0] greeting_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = "H";
            5'd1:    b = "e";
            5'd2:    b = "l";
            5'd3:    b = "l";
            5'd4:    b = "o";
            5'd5:    b = " ";
            5'd6:    b = "f";
            5'd7:    b = "r";
            5'd8:    b = "o";
            5'd9:    b = "m";
            5'd10:   b = " ";
            5'd11:   b = "T";
            5'd12:   b = "U";
            5'd13:   b = "N";
            5'd14:   b = " ";
            5'd15:   b = "i";
            5'd16:   b = "n";
            5'd17:   b = "t";
            5'd18:   b = "e";
            5'd19:   b = "r";
            5'd20:   b = "f";
            5'd21:   b = "a";
            5'd22:   b = "c";
            5'd23:   b = "e";
            5'd24:   b = "!";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### design/ufrg_parser.sv
module ufrg_parser #(
    parameter int REPLY_PAYLOAD_BYTES = 26
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ufrg_pkg::in_item_t     in_data,
    output logic                   pend_valid,
    output ufrg_pkg::reply_desc_t  pend_desc,
    input  logic                   pend_take
);

    localparam int TOTAL_BYTES = ufrg_pkg::IP_HDR_BYTES + ufrg_pkg::UDP_HDR_BYTES
                                 + REPLY_PAYLOAD_BYTES;
    localparam logic [18:0] CSUM_BASE = 19'({ufrg_pkg::VERSION_IHL, 8'h00})
                                        + 19'(TOTAL_BYTES)
                                        + 19'({ufrg_pkg::REPLY_TTL, ufrg_pkg::PROTO_UDP});
    localparam logic [6:0] POS_MAX   = 7'h7F;
    localparam logic [6:0] POS_IHL   = 7'd0;
    localparam logic [6:0] POS_PROTO = 7'd9;
    localparam logic [6:0] POS_SRC   = 7'd12;
    localparam logic [6:0] POS_DST   = 7'd16;

    logic [6:0]  pos_reg, pos_next;
    logic [3:0]  hw_reg, hw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic        pend_valid_reg, pend_valid_next;
    ufrg_pkg::reply_desc_t pend_desc_reg, pend_desc_next;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  port_at;
    logic [6:0]  port_off;
    logic        reply_hit;
    logic [18:0] sum0;
    logic [16:0] sum1;
    logic [15:0] sum2;

    assign accept     = in_valid && in_ready;
    assign in_ready   = !pend_valid_reg || pend_take;
    assign pend_valid = pend_valid_reg;
    assign pend_desc  = pend_desc_reg;
    assign b          = in_data.in_byte;

    // Addresses are complete well before the port bytes, so the registered copies are used.
    assign sum0 = CSUM_BASE + 19'(src_reg[31:16]) + 19'(src_reg[15:0])
                  + 19'(dst_reg[31:16]) + 19'(dst_reg[15:0]);
    assign sum1 = 17'(sum0[15:0]) + 17'(sum0[18:16]);
    assign sum2 = sum1[15:0] + 16'(sum1[16]);

    always_comb
    begin
        hw_next    = hw_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;

        if (pos_reg == POS_IHL)
        begin
            hw_next = b[3:0];
        end
        else if (pos_reg == POS_PROTO)
        begin
            proto_next = b;
        end
        else if (pos_reg >= POS_SRC && pos_reg < POS_DST)
        begin
            src_next = {src_reg[23:0], b};
        end
        else if (pos_reg >= POS_DST && pos_reg < POS_DST + 7'd4)
        begin
            dst_next = {dst_reg[23:0], b};
        end

        port_at  = {1'b0, hw_next, 2'b00};
        port_off = pos_reg - port_at;
        if (hw_next >= ufrg_pkg::MIN_IHL && pos_reg >= port_at && port_off < 7'd4)
        begin
            if (!port_off[1])
            begin
                sport_next = {sport_reg[7:0], b};
            end
            else
            begin
                dport_next = {dport_reg[7:0], b};
            end
        end

        reply_hit = in_data.in_last && proto_next == ufrg_pkg::PROTO_UDP
                    && hw_next >= ufrg_pkg::MIN_IHL && pos_reg >= port_at + 7'd3;

        if (in_data.in_last)
        begin
            pos_next = '0;
        end
        else if (pos_reg == POS_MAX)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            pos_next = pos_reg + 7'd1;
        end

        pend_valid_next = (accept && reply_hit) || (pend_valid_reg && !pend_take);

        pend_desc_next          = pend_desc_reg;
        pend_desc_next.src_addr = src_next;
        pend_desc_next.dst_addr = dst_next;
        pend_desc_next.sport    = sport_next;
        pend_desc_next.dport    = dport_next;
        pend_desc_next.checksum = ~sum2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            hw_reg         <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                pos_reg   <= pos_next;
                hw_reg    <= hw_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && reply_hit)
        begin
            pend_desc_reg <= pend_desc_next;
        end
    end

endmodule

### design/ufrg_emitter.sv
module ufrg_emitter #(
    parameter int REPLY_PAYLOAD_BYTES = 26
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pend_valid,
    input  ufrg_pkg::reply_desc_t  pend_desc,
    output logic                   pend_take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ufrg_pkg::out_item_t    out_data
);

    localparam int TOTAL_BYTES = ufrg_pkg::IP_HDR_BYTES + ufrg_pkg::UDP_HDR_BYTES
                                 + REPLY_PAYLOAD_BYTES;
    localparam int UDP_BYTES   = ufrg_pkg::UDP_HDR_BYTES + REPLY_PAYLOAD_BYTES;
    localparam logic [15:0] TOTAL_LEN = 16'(TOTAL_BYTES);
    localparam logic [15:0] UDP_LEN   = 16'(UDP_BYTES);
    localparam logic [5:0]  LAST_IDX  = 6'(TOTAL_BYTES - 1);
    localparam logic [5:0]  PAYLOAD_START = 6'(ufrg_pkg::IP_HDR_BYTES + ufrg_pkg::UDP_HDR_BYTES);

    logic [5:0]  idx_reg, idx_next;
    logic        act_valid_reg, act_valid_next;
    ufrg_pkg::reply_desc_t act_reg, act_next;
    logic        out_valid_reg, out_valid_next;
    ufrg_pkg::out_item_t out_reg, out_next;

    logic        adv;
    logic        at_end;
    logic [5:0]  pay_idx;
    logic [7:0]  cur_byte;

    assign adv       = act_valid_reg && (!out_valid_reg || out_ready);
    assign at_end    = idx_reg == LAST_IDX;
    assign pend_take = pend_valid && (!act_valid_reg || (adv && at_end));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pay_idx   = idx_reg - PAYLOAD_START;

    always_comb
    begin
        case (idx_reg)
            6'd0:    cur_byte = ufrg_pkg::VERSION_IHL;
            6'd2:    cur_byte = TOTAL_LEN[15:8];
            6'd3:    cur_byte = TOTAL_LEN[7:0];
            6'd8:    cur_byte = ufrg_pkg::REPLY_TTL;
            6'd9:    cur_byte = ufrg_pkg::PROTO_UDP;
            6'd10:   cur_byte = act_reg.checksum[15:8];
            6'd11:   cur_byte = act_reg.checksum[7:0];
            6'd12:   cur_byte = act_reg.dst_addr[31:24];
            6'd13:   cur_byte = act_reg.dst_addr[23:16];
            6'd14:   cur_byte = act_reg.dst_addr[15:8];
            6'd15:   cur_byte = act_reg.dst_addr[7:0];
            6'd16:   cur_byte = act_reg.src_addr[31:24];
            6'd17:   cur_byte = act_reg.src_addr[23:16];
            6'd18:   cur_byte = act_reg.src_addr[15:8];
            6'd19:   cur_byte = act_reg.src_addr[7:0];
            6'd20:   cur_byte = act_reg.dport[15:8];
            6'd21:   cur_byte = act_reg.dport[7:0];
            6'd22:   cur_byte = act_reg.sport[15:8];
            6'd23:   cur_byte = act_reg.sport[7:0];
            6'd24:   cur_byte = UDP_LEN[15:8];
            6'd25:   cur_byte = UDP_LEN[7:0];
            default:
            begin
                if (idx_reg >= PAYLOAD_START)
                begin
                    cur_byte = ufrg_pkg::greeting_byte(pay_idx[4:0]);
                end
                else
                begin
                    cur_byte = 8'h00;
                end
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (adv)
        begin
            idx_next          = idx_reg + 6'd1;
            out_valid_next    = 1'b1;
            out_next.out_byte = cur_byte;
            out_next.out_last = at_end;
            if (at_end)
            begin
                act_valid_next = 1'b0;
                idx_next       = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_take)
        begin
            act_valid_next = 1'b1;
            act_next       = pend_desc;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            act_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            act_valid_reg <= act_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        out_reg <= out_next;
    end

endmodule

### design/udp_fixed_reply_generator.sv
// Answers every well-formed UDP over IPv4 packet with a fixed UDP reply.
// Input channel: in_valid / in_ready / in_data, one packet byte per item in
// network order, with in_last set on the final byte of each packet.
// Output channel: out_valid / out_ready / out_data, one reply byte per item,
// with out_last set on the final byte. A reply is 28 + REPLY_PAYLOAD_BYTES
// bytes: IPv4 header with swapped addresses and a fresh checksum, UDP header
// with swapped ports, then the start of a fixed greeting.
// Throughput is one item per cycle on each channel while its ready is high.
// When idle, a reply goes from the waiting slot to the emitter's active
// register, then its first byte is registered on the output; the rest follow
// one per cycle while out_ready is high. Reception of the next packet overlaps
// the emission of a reply; one further finished reply is held in a waiting
// slot, and in_ready drops only while that slot is occupied and its contents
// are not being taken in that cycle. A stall on the output simply holds the
// current byte and the reply counter. Reset clears the byte position, the
// captured header fields and all valid flags; no reply is pending after reset.
module udp_fixed_reply_generator #(
    parameter int REPLY_PAYLOAD_BYTES = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ufrg_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ufrg_pkg::out_item_t  out_data
);

    logic                  pend_valid;
    logic                  pend_take;
    ufrg_pkg::reply_desc_t pend_desc;

    ufrg_parser #(
        .REPLY_PAYLOAD_BYTES(REPLY_PAYLOAD_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .pend_valid (pend_valid),
        .pend_desc  (pend_desc),
        .pend_take  (pend_take)
    );

    ufrg_emitter #(
        .REPLY_PAYLOAD_BYTES(REPLY_PAYLOAD_BYTES)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend_desc  (pend_desc),
        .pend_take  (pend_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### design/ufrg_checker.sv
module ufrg_checker #(
    parameter int REPLY_PAYLOAD_BYTES = 26
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input ufrg_pkg::out_item_t  out_data
);

    localparam int TOTAL_BYTES = ufrg_pkg::IP_HDR_BYTES + ufrg_pkg::UDP_HDR_BYTES
                                 + REPLY_PAYLOAD_BYTES;
    localparam logic [5:0] LAST_IDX = 6'(TOTAL_BYTES - 1);

    logic [5:0] cnt_reg, cnt_next;
    logic       out_acc;

    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (out_acc)
        begin
            if (out_data.out_last)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled output item must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output item changed while stalled.");

    // The last mark appears exactly on the final byte of a reply.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_data.out_last == (cnt_reg == LAST_IDX)))
        else $error("Reply length or last mark is wrong.");

    // Each reply opens with the fixed version and header length byte.
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cnt_reg == 6'd0 |-> out_data.out_byte == ufrg_pkg::VERSION_IHL)
        else $error("Reply does not start with the IPv4 version byte.");

    // The protocol byte of every reply is UDP.
    a_proto_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cnt_reg == 6'd9 |-> out_data.out_byte == ufrg_pkg::PROTO_UDP)
        else $error("Reply protocol byte is not UDP.");

    // Straight after reset no output item is shown.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("Output item shown straight after reset.");

endmodule

bind udp_fixed_reply_generator ufrg_checker #(
    .REPLY_PAYLOAD_BYTES(REPLY_PAYLOAD_BYTES)
) u_ufrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
